[hw/rtl/u32u16_pkg.sv]
package u32u16_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] MARK_BIG    = 32'h0000_FEFF;
  localparam logic [31:0] MARK_LITTLE = 32'hFFFE_0000;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  typedef enum logic [1:0] {
    ORDER_NONE   = 2'd0,
    ORDER_BIG    = 2'd1,
    ORDER_LITTLE = 2'd2,
    ORDER_RSVD   = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    KIND_UNIT = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // payload: code point for a single unit, code point minus 0x10000 for a pair
  typedef struct packed {
    kind_t       kind;
    logic [19:0] payload;
  } entry_t;

endpackage

[hw/rtl/u32u16_front.sv]
module u32u16_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 new_stream,
  output logic                 push,
  output u32u16_pkg::entry_t   entry
);

  logic [1:0]          exp_order_r;
  u32u16_pkg::order_t  order_r, order_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [23:0]         partial_r, partial_nxt;

  u32u16_pkg::order_t  exp_eff;
  u32u16_pkg::order_t  order_eff;
  u32u16_pkg::order_t  order_use;
  logic [1:0]          idx_eff;
  logic [23:0]         partial_eff;
  logic [31:0]         word;
  logic [31:0]         cp;
  logic                is_mark;
  logic                complete;
  logic [19:0]         pair_v;

  always_comb begin
    exp_eff = (exp_order_r == 2'd3) ? u32u16_pkg::ORDER_NONE
                                    : u32u16_pkg::order_t'(exp_order_r);
    order_eff   = new_stream ? u32u16_pkg::ORDER_NONE : order_r;
    idx_eff     = new_stream ? 2'd0 : idx_r;
    partial_eff = new_stream ? 24'd0 : partial_r;
    word        = {partial_eff, data_byte};
    complete    = (idx_eff == 2'd3);

    is_mark   = 1'b0;
    order_use = order_eff;
    if (order_eff == u32u16_pkg::ORDER_NONE) begin
      if (word == u32u16_pkg::MARK_BIG && exp_eff != u32u16_pkg::ORDER_LITTLE) begin
        is_mark   = 1'b1;
        order_use = u32u16_pkg::ORDER_BIG;
      end else if (word == u32u16_pkg::MARK_LITTLE && exp_eff != u32u16_pkg::ORDER_BIG) begin
        is_mark   = 1'b1;
        order_use = u32u16_pkg::ORDER_LITTLE;
      end else begin
        order_use = (exp_eff == u32u16_pkg::ORDER_NONE) ? u32u16_pkg::ORDER_BIG : exp_eff;
      end
    end

    cp = (order_use == u32u16_pkg::ORDER_LITTLE)
         ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
    // only pair-range points use this, so the low 20 bits suffice
    pair_v = cp[19:0] - 20'h10000;

    if (cp[31:16] == 16'd0) begin
      entry.kind    = u32u16_pkg::KIND_UNIT;
      entry.payload = {4'd0, cp[15:0]};
    end else if (cp[31:21] == 11'd0 && (!cp[20] || cp[19:16] == 4'd0)) begin
      entry.kind    = u32u16_pkg::KIND_PAIR;
      entry.payload = pair_v;
    end else begin
      entry.kind    = u32u16_pkg::KIND_BAD;
      entry.payload = 20'd0;
    end

    push = accept && complete && !is_mark;

    order_nxt   = order_r;
    idx_nxt     = idx_r;
    partial_nxt = partial_r;
    if (accept) begin
      idx_nxt = idx_eff + 2'd1;
      if (complete) begin
        partial_nxt = 24'd0;
        order_nxt   = order_use;
      end else begin
        partial_nxt = {partial_eff[15:0], data_byte};
        order_nxt   = order_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_order_r <= 2'd0;
      order_r     <= u32u16_pkg::ORDER_NONE;
      idx_r       <= 2'd0;
      partial_r   <= 24'd0;
    end else begin
      if (cfg_wr_en) begin
        exp_order_r <= cfg_wr_data;
      end
      order_r   <= order_nxt;
      idx_r     <= idx_nxt;
      partial_r <= partial_nxt;
    end
  end

`ifndef SYNTHESIS
  a_push_clears_index: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (idx_r == 2'd0 && partial_r == 24'd0))
    else $error("word completed but byte index not cleared");

  a_order_fixed_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (order_r == u32u16_pkg::ORDER_BIG || order_r == u32u16_pkg::ORDER_LITTLE))
    else $error("byte order undecided after a decoded word");
`endif

endmodule

[hw/rtl/u32u16_queue.sv]
module u32u16_queue #(
  parameter int unsigned DEPTH = u32u16_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u32u16_pkg::entry_t   push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output u32u16_pkg::entry_t   head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  u32u16_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full       = (count_r == DEPTH_C);
    head_valid = (count_r != '0);
    head       = slot_r[rptr_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wptr_nxt   = do_push ? ((wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1) : wptr_r;
    rptr_nxt   = do_pop ? ((rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1) : rptr_r;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count out of range");
`endif

endmodule

[hw/rtl/u32u16_back.sv]
module u32u16_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  u32u16_pkg::entry_t   head,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        bad_r, bad_nxt;
  logic        last_r, last_nxt;
  logic        load;

  always_comb begin
    load      = !valid_r || out_tready;
    valid_nxt = load ? head_valid : valid_r;
    phase_nxt = phase_r;
    unit_nxt  = unit_r;
    bad_nxt   = bad_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load && head_valid) begin
      unique case (head.kind)
        u32u16_pkg::KIND_UNIT: begin
          unit_nxt = head.payload[15:0];
          bad_nxt  = 1'b0;
          last_nxt = 1'b1;
          pop      = 1'b1;
        end
        u32u16_pkg::KIND_PAIR: begin
          bad_nxt   = 1'b0;
          phase_nxt = !phase_r;
          if (phase_r) begin
            unit_nxt = {u32u16_pkg::LO_SURR_TAG, head.payload[9:0]};
            last_nxt = 1'b1;
            pop      = 1'b1;
          end else begin
            unit_nxt = {u32u16_pkg::HI_SURR_TAG, head.payload[19:10]};
            last_nxt = 1'b0;
          end
        end
        default: begin
          unit_nxt = 16'd0;
          bad_nxt  = 1'b1;
          last_nxt = 1'b1;
          pop      = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    bad_r  <= bad_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = unit_r;
  assign out_tuser  = bad_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_phase_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_valid && head.kind == u32u16_pkg::KIND_PAIR))
    else $error("second half pending without a pair at queue head");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && bad_r) |-> (unit_r == 16'd0 && last_r))
    else $error("malformed transaction with nonzero unit");
`endif

endmodule

[hw/rtl/utf32_to_utf16_decoder_top.sv]
// UTF-32 byte stream to UTF-16 decoder. One byte is taken per cycle while
// in_tready is high; every fourth byte completes a word, which is checked
// for a byte order mark if it is the first of a stream, then decoded into
// one unit, a surrogate pair, or a single malformed transaction (unit zero,
// tuser high). tlast marks the final unit of a word. The front end
// classifies the word in the cycle the byte is accepted and writes it into a
// QUEUE_DEPTH-entry queue; the back end drains it into the output register,
// one unit per cycle while out_tready is high. in_tready drops only while
// that queue is full; sustained input rate is one byte per cycle with
// out_tready high, since four bytes yield at most two units. cfg_wr_data
// sets the expected order: 0 or 3 detect (default big), 1 big-endian,
// 2 little-endian; write it only while the block is idle.
module utf32_to_utf16_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = u32u16_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // expected_order
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tuser,      // [0] new_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [15:0] code_unit
  output logic        out_tuser,     // [0] malformed
  output logic        out_tlast
);

  logic               accept;
  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  u32u16_pkg::entry_t push_entry;
  u32u16_pkg::entry_t head;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  u32u16_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .data_byte   (in_tdata),
    .new_stream  (in_tuser),
    .push        (push),
    .entry       (push_entry)
  );

  u32u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  u32u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/utf32_to_utf16_decoder_top_tb.sv]
`timescale 1ns / 100ps

module utf32_to_utf16_decoder_top_tb;

  localparam int LAT        = u32u16_pkg::QUEUE_DEPTH + 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASE_LEN  = 228;
  localparam int NUM_PHASES = 8;
  localparam int DIR_ROWS   = 30;

  typedef struct packed {
    logic [15:0] unit;
    logic        bad;
    logic        fin;
  } u16_result_t;

  // one byte transaction, plus the typed expectation for directed rows
  typedef struct packed {
    logic               wr;
    u32u16_pkg::order_t order;
    logic [7:0]         b;
    logic               ns;
    logic               typed;
    logic [1:0]         n;
    logic [15:0]        u0;
    logic [15:0]        u1;
    logic               bad;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;   // expected_order
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;      // [7:0] data_byte
  logic        in_tuser;      // [0] new_stream
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;     // [15:0] code_unit
  logic        out_tuser;     // [0] malformed
  logic        out_tlast;

  dir_row_t    drv_row;
  int          hold_phase;

  // predictor state
  u32u16_pkg::order_t cfg_order  = u32u16_pkg::ORDER_NONE;
  u32u16_pkg::order_t seen_order = u32u16_pkg::ORDER_NONE;
  logic [1:0]  byte_cnt   = 2'd0;
  logic [23:0] held_bytes = 24'd0;
  u16_result_t unit_fifo[$];

  int errors     = 0;
  int bytes_sent = 0;
  int units_seen = 0;
  int cfg_writes = 0;
  int burst_left = 0;

  dir_row_t           dir_tab [0:DIR_ROWS-1];
  u32u16_pkg::order_t phase_cfg [0:NUM_PHASES-1];

  utf32_to_utf16_decoder_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // advance the decoder model by one byte, queueing the units it yields
  function automatic void decode_byte(input logic [7:0] b, input logic ns);
    u32u16_pkg::order_t want;
    logic [31:0] w;
    logic [31:0] cp;
    logic [31:0] v;
    want = (cfg_order == u32u16_pkg::ORDER_RSVD) ? u32u16_pkg::ORDER_NONE : cfg_order;
    if (ns) begin
      seen_order = u32u16_pkg::ORDER_NONE;
      byte_cnt   = 2'd0;
      held_bytes = 24'd0;
    end
    if (byte_cnt != 2'd3) begin
      held_bytes = {held_bytes[15:0], b};
      byte_cnt   = byte_cnt + 2'd1;
      return;
    end
    w          = {held_bytes, b};
    byte_cnt   = 2'd0;
    held_bytes = 24'd0;
    // mark test only on the first word of a stream
    if (seen_order == u32u16_pkg::ORDER_NONE) begin
      if (w == u32u16_pkg::MARK_BIG && want != u32u16_pkg::ORDER_LITTLE) begin
        seen_order = u32u16_pkg::ORDER_BIG;
        return;
      end
      if (w == u32u16_pkg::MARK_LITTLE && want != u32u16_pkg::ORDER_BIG) begin
        seen_order = u32u16_pkg::ORDER_LITTLE;
        return;
      end
      seen_order = (want == u32u16_pkg::ORDER_NONE) ? u32u16_pkg::ORDER_BIG : want;
    end
    cp = (seen_order == u32u16_pkg::ORDER_BIG) ? w
                                               : {w[7:0], w[15:8], w[23:16], w[31:24]};
    if (cp < 32'h0001_0000) begin
      unit_fifo.push_back({cp[15:0], 1'b0, 1'b1});
    end else if (cp <= 32'h0010_FFFF) begin
      v = cp - 32'h0001_0000;
      unit_fifo.push_back({16'hD800 | {6'd0, v[19:10]}, 1'b0, 1'b0});
      unit_fifo.push_back({16'hDC00 | {6'd0, v[9:0]}, 1'b0, 1'b1});
    end else begin
      unit_fifo.push_back({16'h0000, 1'b1, 1'b1});
    end
  endfunction

  function automatic dir_row_t dir_entry(input logic wr, input u32u16_pkg::order_t order,
                                         input logic [7:0] b, input logic ns,
                                         input logic typed, input logic [1:0] n,
                                         input logic [15:0] u0, input logic [15:0] u1,
                                         input logic bad);
    dir_row_t r;
    r.wr = wr; r.order = order; r.b = b; r.ns = ns; r.typed = typed;
    r.n = n; r.u0 = u0; r.u1 = u1; r.bad = bad;
    return r;
  endfunction

  function automatic logic [31:0] pick_point();
    logic [31:0] cp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cp = {16'h0000, 16'($urandom)};
      4:          cp = $urandom_range(32'hD800, 32'hDFFF);
      5, 6, 7:    cp = $urandom_range(32'h0001_0000, 32'h0010_FFFF);
      8: begin
        case ($urandom_range(0, 7))
          0: cp = 32'h0000_0000;
          1: cp = 32'h0000_FFFF;
          2: cp = 32'h0001_0000;
          3: cp = 32'h0010_FFFF;
          4: cp = 32'h0011_0000;
          5: cp = 32'hFFFF_FFFF;
          6: cp = 32'h0000_D800;
          default: cp = 32'h0000_DFFF;
        endcase
      end
      default: cp = $urandom;
    endcase
    return cp;
  endfunction

  // scoreboard: output side first, a result never stems from the same-edge input
  always @(posedge clk) begin : scoreboard
    u16_result_t want;
    int          depth0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (unit_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction: expected none, actual unit %h malformed %b last %b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = unit_fifo.pop_front();
          units_seen++;
          if (out_tdata !== want.unit) begin
            errors++;
            $display("%0t: code_unit expected %h actual %h", $time, want.unit, out_tdata);
          end
          if (out_tuser !== want.bad) begin
            errors++;
            $display("%0t: malformed expected %b actual %b", $time, want.bad, out_tuser);
          end
          if (out_tlast !== want.fin) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.fin, out_tlast);
          end
        end
      end
      if (cfg_wr_en)
        cfg_order = u32u16_pkg::order_t'(cfg_wr_data);
      if (in_tvalid && in_tready) begin
        depth0 = unit_fifo.size();
        decode_byte(in_tdata, in_tuser);
        if (drv_row.typed) begin
          while (unit_fifo.size() > depth0)
            void'(unit_fifo.pop_back());
          if (drv_row.n == 2'd1) begin
            unit_fifo.push_back({drv_row.u0, drv_row.bad, 1'b1});
          end else if (drv_row.n == 2'd2) begin
            unit_fifo.push_back({drv_row.u0, 1'b0, 1'b0});
            unit_fifo.push_back({drv_row.u1, 1'b0, 1'b1});
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output side backpressure, plus one long hold-off on request
  initial begin : sink
    int mode;
    int left;
    int rcv_cyc;
    int last_hold;
    mode = 0;
    left = 0;
    rcv_cyc = 0;
    last_hold = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_phase != last_hold) begin
        last_hold = hold_phase;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      rcv_cyc++;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ((rcv_cyc % 7) < 4);
        default: out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic send_byte(input dir_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r.b;
    in_tuser  <= r.ns;
    drv_row   <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (unit_fifo.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic write_order(input u32u16_pkg::order_t v);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_word(input logic [31:0] w, input logic little, input logic ns);
    logic [7:0] b;
    for (int j = 0; j < 4; j++) begin
      b = little ? w[8*j +: 8] : w[31-8*j -: 8];
      send_byte(dir_entry(1'b0, u32u16_pkg::ORDER_NONE, b, ns && (j == 0), 1'b0, 2'd0,
                          16'd0, 16'd0, 1'b0));
    end
  endtask

  // mostly well-formed streams; occasional stray bytes knock the word alignment
  task automatic gen_stream();
    int   mark;
    int   nwords;
    int   nstray;
    logic little;
    logic first;
    mark   = $urandom_range(0, 3);
    little = 1'($urandom_range(0, 1));
    first  = 1'b1;
    if (mark == 1) little = 1'b0;
    if (mark == 2) little = 1'b1;
    if (mark == 1 || mark == 2) begin
      send_word(32'h0000_FEFF, little, 1'b1);
      first = 1'b0;
    end
    nwords = $urandom_range(1, 10);
    for (int k = 0; k < nwords; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        nstray = $urandom_range(1, 3);
        for (int j = 0; j < nstray; j++)
          send_byte(dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'($urandom),
                              1'($urandom_range(0, 1)), 1'b0, 2'd0, 16'd0, 16'd0, 1'b0));
      end
      send_word(pick_point(), little, first);
      first = 1'b0;
    end
  endtask

  initial begin : stimulus
    int phase_start;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = u32u16_pkg::ORDER_NONE;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = 1'b0;
    drv_row     = '0;
    hold_phase  = 0;

    // rows: wr, order, byte, ns / typ, n, u0, u1, bad
    // little mark detected, then pair at the top of the range, then all-ones
    dir_tab[0]  = dir_entry(1'b1, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b1,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[1]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFE, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[2]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[3]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b1, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[4]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[5]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[6]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h10, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[7]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b1, 2'd2, 16'hDBFF, 16'hDFFF, 1'b0);
    dir_tab[8]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[9]  = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[10] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[11] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1);
    // order write mid-stream: decided little order stays, surrogate passes through
    dir_tab[12] = dir_entry(1'b1, u32u16_pkg::ORDER_BIG, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[13] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hD8, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[14] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[15] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b1, 2'd1, 16'hD800, 16'h0000, 1'b0);
    // little mark forbidden under big order: decoded as data, too large
    dir_tab[16] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b1,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[17] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFE, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[18] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[19] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b1, 2'd1, 16'h0000, 16'h0000, 1'b1);
    // reserved selector, partial word cut by a new stream, then zero and a later mark
    dir_tab[20] = dir_entry(1'b1, u32u16_pkg::ORDER_RSVD, 8'hAB, 1'b1,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[21] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hCD, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[22] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b1,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[23] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[24] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[25] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b1, 2'd1, 16'h0000, 16'h0000, 1'b0);
    dir_tab[26] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[27] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'h00, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[28] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFE, 1'b0,
                            1'b0, 2'd0, 16'h0000, 16'h0000, 1'b0);
    dir_tab[29] = dir_entry(1'b0, u32u16_pkg::ORDER_NONE, 8'hFF, 1'b0,
                            1'b1, 2'd1, 16'hFEFF, 16'h0000, 1'b0);

    phase_cfg[0] = u32u16_pkg::ORDER_NONE;
    phase_cfg[1] = u32u16_pkg::ORDER_BIG;
    phase_cfg[2] = u32u16_pkg::ORDER_LITTLE;
    phase_cfg[3] = u32u16_pkg::ORDER_RSVD;
    phase_cfg[4] = u32u16_pkg::ORDER_NONE;
    phase_cfg[5] = u32u16_pkg::ORDER_LITTLE;
    phase_cfg[6] = u32u16_pkg::ORDER_BIG;
    phase_cfg[7] = u32u16_pkg::ORDER_NONE;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].wr)
        write_order(dir_tab[i].order);
      send_byte(dir_tab[i]);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_order(phase_cfg[ph]);
      // receiver stalls long here while bytes keep coming, queue fills up
      if (ph == 2)
        hold_phase <= ph;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_LEN)
        gen_stream();
    end

    in_tvalid <= 1'b0;
    while (unit_fifo.size() != 0) @(posedge clk);
    repeat (2 * LAT) @(posedge clk);

    $display("Sent %0d bytes over %0d order settings, checked %0d code units",
             bytes_sent, cfg_writes, units_seen);
    $display("Covered marks, surrogate pairs, malformed words and stream restarts under stalls");
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/u32u16_pkg.sv
hw/rtl/u32u16_front.sv
hw/rtl/u32u16_queue.sv
hw/rtl/u32u16_back.sv
hw/rtl/utf32_to_utf16_decoder_top.sv
tb/utf32_to_utf16_decoder_top_tb.sv
